>>> hdl/brz_pkg.sv
// Shared types and constants for the bilinear resize block.
package brz_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int PIXEL_BITS    = 16;
    localparam int SCALE_FRAC    = 16;
    localparam int IDX_BITS      = 12;
    localparam int LEN_BITS      = IDX_BITS + 1;
    localparam int DEN_BITS      = 24;
    localparam int DIV_BITS      = IDX_BITS + FRACTION_BITS + SCALE_FRAC;
    localparam int CNT_BITS      = $clog2(DIV_BITS + 1);
    localparam int W_BITS        = FRACTION_BITS + 1;
    localparam int MAX_SOURCE_HEIGHT_DEF = 256;
    localparam int MAX_SOURCE_WIDTH_DEF  = 256;

    // configuration register indexes
    localparam logic [2:0] REG_CONTROL = 3'd0;
    localparam logic [2:0] REG_SRC_H   = 3'd1;
    localparam logic [2:0] REG_SRC_W   = 3'd2;
    localparam logic [2:0] REG_TGT_H   = 3'd3;
    localparam logic [2:0] REG_TGT_W   = 3'd4;
    localparam logic [2:0] REG_VSCALE  = 3'd5;
    localparam logic [2:0] REG_HSCALE  = 3'd6;
    localparam logic [2:0] REG_FILL    = 3'd7;

    // coordinate modes; half_pixel and the unused codes take the default path
    localparam logic [2:0] MODE_ASYM  = 3'd1;
    localparam logic [2:0] MODE_PYT   = 3'd2;
    localparam logic [2:0] MODE_TFNN  = 3'd3;
    localparam logic [2:0] MODE_ALIGN = 3'd4;
    localparam logic [2:0] MODE_CROP  = 3'd5;

    typedef struct packed {
        logic [3:0]                    control;
        logic [8:0]                    src_h;
        logic [8:0]                    src_w;
        logic [11:0]                   tgt_h;
        logic [11:0]                   tgt_w;
        logic [23:0]                   vscale;
        logic [23:0]                   hscale;
        logic signed [PIXEL_BITS-1:0]  fill;
    } cfg_t;

    typedef struct packed {
        logic       capture;
        logic       load_we;
        logic       setup;
        logic       div_step;
        logic       finish;
        logic       issue;
        logic       mul;
        logic       acc;
        logic       out_load;
        logic       axis;
        logic [1:0] corner;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic fill_hit;
    } stat_t;

endpackage

>>> hdl/bilinear_image_resize.sv
// Bilinear image plane resize: configuration registers, sequencer and datapath.
// Usage:
//   Input channel (in_valid/in_stall): mode 0 writes pixel_in to the image
//   store at (row, column); mode 1 requests output pixel (row, column).
//   Output channel (out_valid/out_stall): one item per request, pixel_out
//   and filled. Loads give no output.
//   Config channel (cfg_valid/cfg_ready, always ready): cfg_index selects
//   control, source_height, source_width, target_height, target_width,
//   vertical_scale, horizontal_scale, fill_value; write only while idle.
//   Sequence: a load leaves the block free for the next item. A request
//   runs from accept to result through two axis mappings (a setup step,
//   44 quotient bits of a restoring divider one a cycle plus a done
//   check, and a finish step), a fill check, a read, a multiply and an
//   accumulate step for each of the four store reads and blends (one RAM
//   read port), and a hand-off. A fill result skips the reads.
//   The next item is taken while the result sits in the output
//   register; if the receiver stalls, the result holds and the following
//   request waits at its last step. Reset clears control state and loads
//   register reset values; the image store is undefined until written.
module bilinear_image_resize #(
    parameter int MAX_SOURCE_HEIGHT = brz_pkg::MAX_SOURCE_HEIGHT_DEF,
    parameter int MAX_SOURCE_WIDTH  = brz_pkg::MAX_SOURCE_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               mode,
    input  logic [11:0]        row,
    input  logic [11:0]        column,
    input  logic signed [15:0] pixel_in,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] pixel_out,
    output logic               filled,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_data
);

    brz_pkg::cfg_t  cfg_reg, cfg_next;
    brz_pkg::cmd_t  cmd;
    brz_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                brz_pkg::REG_CONTROL: cfg_next.control = cfg_data[3:0];
                brz_pkg::REG_SRC_H:   cfg_next.src_h   = cfg_data[8:0];
                brz_pkg::REG_SRC_W:   cfg_next.src_w   = cfg_data[8:0];
                brz_pkg::REG_TGT_H:   cfg_next.tgt_h   = cfg_data[11:0];
                brz_pkg::REG_TGT_W:   cfg_next.tgt_w   = cfg_data[11:0];
                brz_pkg::REG_VSCALE:  cfg_next.vscale  = cfg_data[23:0];
                brz_pkg::REG_HSCALE:  cfg_next.hscale  = cfg_data[23:0];
                brz_pkg::REG_FILL:    cfg_next.fill    = cfg_data[15:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.control <= 4'd0;
            cfg_reg.src_h   <= 9'd1;
            cfg_reg.src_w   <= 9'd1;
            cfg_reg.tgt_h   <= 12'd1;
            cfg_reg.tgt_w   <= 12'd1;
            cfg_reg.vscale  <= 24'd65536;
            cfg_reg.hscale  <= 24'd65536;
            cfg_reg.fill    <= 16'sd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    brz_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .mode      (mode),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    brz_datapath #(
        .MAX_SOURCE_HEIGHT (MAX_SOURCE_HEIGHT),
        .MAX_SOURCE_WIDTH  (MAX_SOURCE_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd       (cmd),
        .row       (row),
        .column    (column),
        .pixel_in  (pixel_in),
        .stat      (stat),
        .pixel_out (pixel_out),
        .filled    (filled)
    );

`ifndef NO_ASSERTIONS
    // a request keeps the block busy on the following cycle
    a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && mode |=> in_stall)
        else $error("request did not start the sequencer");

    // a load completes in the cycle it is taken
    a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !mode |=> !in_stall)
        else $error("load left the block busy");

    // a filled result carries the configured fill value
    a_fill_val: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && filled |-> pixel_out == cfg_reg.fill)
        else $error("filled result does not match fill value");
`endif

endmodule

>>> hdl/brz_ram.sv
// Generic simple dual-port RAM with registered read.
module brz_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/brz_datapath.sv
// Coordinate mapping, shared divider, corner blend and output payload.
module brz_datapath #(
    parameter int MAX_SOURCE_HEIGHT = brz_pkg::MAX_SOURCE_HEIGHT_DEF,
    parameter int MAX_SOURCE_WIDTH  = brz_pkg::MAX_SOURCE_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  brz_pkg::cfg_t                       cfg,
    input  brz_pkg::cmd_t                       cmd,
    input  logic [11:0]                         row,
    input  logic [11:0]                         column,
    input  logic signed [brz_pkg::PIXEL_BITS-1:0] pixel_in,
    output brz_pkg::stat_t                      stat,
    output logic signed [brz_pkg::PIXEL_BITS-1:0] pixel_out,
    output logic                                filled
);

    localparam int DEPTH = MAX_SOURCE_HEIGHT * MAX_SOURCE_WIDTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FB    = brz_pkg::FRACTION_BITS;
    localparam int PB    = brz_pkg::PIXEL_BITS;
    localparam int IB    = brz_pkg::IDX_BITS;
    localparam int LB    = brz_pkg::LEN_BITS;
    localparam int DB    = brz_pkg::DIV_BITS;
    localparam int NB    = brz_pkg::DEN_BITS;
    localparam int WB    = brz_pkg::W_BITS;
    localparam int CB    = IB + FB;
    localparam int SB    = DB + 2;
    localparam int PRB   = WB + 1 + PB;
    localparam int AB    = PRB + 6;

    localparam logic [23:0] SCALE_ONE = 24'd65536;

    localparam logic [WB-1:0] W_ONE  = WB'(1) << FB;
    localparam logic [WB-1:0] W_HALF = WB'(1) << (FB - 1);

    logic [IB-1:0] qr_reg, qc_reg;
    logic [DB-1:0] d_reg;
    logic [NB-1:0] den_reg;
    logic [NB-1:0] rem_reg;
    logic [brz_pkg::CNT_BITS-1:0] cnt_reg;
    logic          sub_reg;
    logic [IB-1:0] y_lo_reg, y_hi_reg, x_lo_reg, x_hi_reg;
    logic [WB-1:0] wy_lo_reg, wy_hi_reg, wx_lo_reg, wx_hi_reg;
    logic          y_out_reg, x_out_reg;
    logic [WB-1:0] cw_reg;
    logic signed [PRB-1:0] prod_reg;
    logic signed [AB-1:0]  acc_reg;
    logic signed [PB-1:0]  pixel_out_reg;
    logic                  filled_reg;

    // effective lengths
    logic [LB-1:0] sh, sw, th, tw, sl, tl;
    logic [IB-1:0] sm1, q;
    logic [23:0]   scale, s0;
    logic [2:0]    md;

    always_comb
    begin
        if (cfg.src_h == 9'd0)
            sh = LB'(1);
        else if ({4'b0, cfg.src_h} > LB'(MAX_SOURCE_HEIGHT))
            sh = LB'(MAX_SOURCE_HEIGHT);
        else
            sh = {4'b0, cfg.src_h};
        if (cfg.src_w == 9'd0)
            sw = LB'(1);
        else if ({4'b0, cfg.src_w} > LB'(MAX_SOURCE_WIDTH))
            sw = LB'(MAX_SOURCE_WIDTH);
        else
            sw = {4'b0, cfg.src_w};
        th = (cfg.tgt_h == 12'd0) ? LB'(1) : {1'b0, cfg.tgt_h};
        tw = (cfg.tgt_w == 12'd0) ? LB'(1) : {1'b0, cfg.tgt_w};
    end

    assign sl    = cmd.axis ? sw : sh;
    assign tl    = cmd.axis ? tw : th;
    assign q     = cmd.axis ? qc_reg : qr_reg;
    assign scale = cmd.axis ? cfg.hscale : cfg.vscale;
    assign s0    = (scale == 24'd0) ? 24'd1 : scale;
    assign sm1   = IB'(sl - LB'(1));
    assign md    = cfg.control[2:0];

    // dividend/divisor setup; fixed values go through the divider by one
    logic [DB-1:0] set_d;
    logic [NB-1:0] set_den;
    logic          set_sub;
    logic [CB-1:0] qh;
    logic [2*IB-1:0] qs;

    assign qh = {q, FB'(0)} + CB'(W_HALF);
    assign qs = q * sm1;

    always_comb
    begin
        set_sub = 1'b0;
        set_den = NB'(1);
        if (scale == SCALE_ONE)
            set_d = DB'({q, FB'(0)});
        else if (md == brz_pkg::MODE_ASYM)
        begin
            set_d   = {q, FB'(0), 16'b0};
            set_den = s0;
        end
        else if (md == brz_pkg::MODE_TFNN)
        begin
            set_d   = {qh, 16'b0};
            set_den = s0;
        end
        else if (md == brz_pkg::MODE_ALIGN || md == brz_pkg::MODE_CROP)
        begin
            if (tl <= LB'(1))
                set_d = (md == brz_pkg::MODE_ALIGN) ? DB'(0) : DB'({sm1, (FB - 1)'(0)});
            else
            begin
                set_d   = DB'({qs, FB'(0)});
                set_den = NB'(tl - LB'(1));
            end
        end
        else if (md == brz_pkg::MODE_PYT && tl <= LB'(1))
            set_d = DB'(0);
        else
        begin
            set_d   = {qh, 16'b0};
            set_den = s0;
            set_sub = 1'b1;
        end
    end

    // restoring divider, one quotient bit per cycle
    logic [NB:0] rem_shift;
    logic        ge;
    assign rem_shift = {rem_reg, d_reg[DB-1]};
    assign ge        = rem_shift >= {1'b0, den_reg};

    // clamp and neighbour pick
    logic signed [SB-1:0] c, topv;
    logic [CB-1:0]        cc;
    logic                 outside, at_edge;
    logic [IB-1:0]        i_lo, i_hi;
    logic [FB-1:0]        frac;
    logic [WB-1:0]        w_lo, w_hi;

    always_comb
    begin
        c    = $signed({2'b0, d_reg}) - (sub_reg ? SB'(W_HALF) : SB'(0));
        topv = $signed(SB'({sm1, FB'(0)}));
        outside = (c < 0) || (c > topv);
        if (c < 0)
            cc = CB'(0);
        else if (c > topv)
            cc = {sm1, FB'(0)};
        else
            cc = c[CB-1:0];
        i_lo    = cc[CB-1:FB];
        frac    = cc[FB-1:0];
        at_edge = (i_lo == sm1);
        i_hi    = at_edge ? i_lo : i_lo + IB'(1);
        w_lo    = at_edge ? W_HALF : W_ONE - WB'(frac);
        w_hi    = at_edge ? W_HALF : WB'(frac);
    end

    // corner select
    logic [IB-1:0]   cy, cx;
    logic [WB-1:0]   wy, wx;
    logic [2*WB-1:0] wprod;
    logic [31:0]     raddr_full, waddr_full;
    logic [AW-1:0]   raddr, waddr;
    logic signed [PB-1:0] rdata;
    logic            we;

    assign cy    = cmd.corner[1] ? y_hi_reg : y_lo_reg;
    assign cx    = cmd.corner[0] ? x_hi_reg : x_lo_reg;
    assign wy    = cmd.corner[1] ? wy_hi_reg : wy_lo_reg;
    assign wx    = cmd.corner[0] ? wx_hi_reg : wx_lo_reg;
    assign wprod = wy * wx;

    assign raddr_full = {20'b0, cy} * 32'(MAX_SOURCE_WIDTH) + {20'b0, cx};
    assign waddr_full = {20'b0, row} * 32'(MAX_SOURCE_WIDTH) + {20'b0, column};
    assign raddr      = raddr_full[AW-1:0];
    assign waddr      = waddr_full[AW-1:0];
    assign we = cmd.load_we && ({1'b0, row} < LB'(MAX_SOURCE_HEIGHT))
                && ({1'b0, column} < LB'(MAX_SOURCE_WIDTH));

    brz_ram #(
        .WIDTH (PB),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (pixel_in),
        .raddr (raddr),
        .rdata (rdata)
    );

    // round half up, saturate
    logic signed [AB-1:0]    rsum;
    logic signed [AB-FB-1:0] rq;
    logic signed [PB-1:0]    sat;
    localparam logic signed [AB-FB-1:0] PMAX = (AB-FB)'((1 << (PB - 1)) - 1);
    localparam logic signed [AB-FB-1:0] PMIN = -PMAX - (AB-FB)'(1);

    always_comb
    begin
        rsum = acc_reg + AB'(W_HALF);
        rq   = rsum[AB-1:FB];
        if (rq > PMAX)
            sat = PB'(PMAX);
        else if (rq < PMIN)
            sat = PB'(PMIN);
        else
            sat = rq[PB-1:0];
    end

    assign stat.div_done = (cnt_reg == brz_pkg::CNT_BITS'(DB));
    assign stat.fill_hit = cfg.control[3] && (y_out_reg || x_out_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.setup)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg + brz_pkg::CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            qr_reg  <= row;
            qc_reg  <= column;
            acc_reg <= '0;
        end
        if (cmd.setup)
        begin
            d_reg   <= set_d;
            den_reg <= set_den;
            sub_reg <= set_sub;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= ge ? NB'(rem_shift - {1'b0, den_reg}) : rem_shift[NB-1:0];
            d_reg   <= {d_reg[DB-2:0], ge};
        end
        if (cmd.finish)
        begin
            if (cmd.axis)
            begin
                x_lo_reg  <= i_lo;
                x_hi_reg  <= i_hi;
                wx_lo_reg <= w_lo;
                wx_hi_reg <= w_hi;
                x_out_reg <= outside;
            end
            else
            begin
                y_lo_reg  <= i_lo;
                y_hi_reg  <= i_hi;
                wy_lo_reg <= w_lo;
                wy_hi_reg <= w_hi;
                y_out_reg <= outside;
            end
        end
        if (cmd.issue)
        begin
            cw_reg <= wprod[FB+WB-1:FB];
        end
        if (cmd.mul)
        begin
            prod_reg <= $signed({1'b0, cw_reg}) * rdata;
        end
        if (cmd.acc)
        begin
            acc_reg <= acc_reg + AB'(prod_reg);
        end
        if (cmd.out_load)
        begin
            pixel_out_reg <= stat.fill_hit ? cfg.fill : sat;
            filled_reg    <= stat.fill_hit;
        end
    end

    assign pixel_out = pixel_out_reg;
    assign filled    = filled_reg;

endmodule

>>> hdl/brz_ctrl.sv
// Sequencer for one item: axis mapping, four corner reads, output hand-off.
module brz_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           mode,
    output logic           in_stall,
    output logic           out_valid,
    input  logic           out_stall,
    input  brz_pkg::stat_t stat,
    output brz_pkg::cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_SETUP, S_DIV, S_FIN, S_CHK, S_RD, S_MUL, S_ACC, S_DONE
    } state_t;

    state_t     state_reg, state_next;
    logic       axis_reg, axis_next;
    logic [1:0] corner_reg, corner_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept, out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        cmd.axis       = axis_reg;
        cmd.corner     = corner_reg;
        state_next     = state_reg;
        axis_next      = axis_reg;
        corner_next    = corner_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (mode)
                    begin
                        cmd.capture = 1'b1;
                        axis_next   = 1'b0;
                        state_next  = S_SETUP;
                    end
                    else
                    begin
                        cmd.load_we = 1'b1;
                    end
                end
            end
            S_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (stat.div_done)
                    state_next = S_FIN;
                else
                    cmd.div_step = 1'b1;
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                if (axis_reg)
                    state_next = S_CHK;
                else
                begin
                    axis_next  = 1'b1;
                    state_next = S_SETUP;
                end
            end
            S_CHK:
            begin
                corner_next = 2'd0;
                state_next  = stat.fill_hit ? S_DONE : S_RD;
            end
            S_RD:
            begin
                cmd.issue  = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc     = 1'b1;
                corner_next = corner_reg + 2'd1;
                state_next  = (corner_reg == 2'd3) ? S_DONE : S_RD;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            axis_reg      <= 1'b0;
            corner_reg    <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            corner_reg    <= corner_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> dv/tb.sv
// Testbench for the bilinear resize block: scoreboard, drivers and run control.
class resize_scoreboard;
    int errors;
    logic signed [15:0] exp_pix[$];
    logic               exp_fill[$];

    function new();
        errors = 0;
    endfunction

    function void note_request(logic signed [15:0] pix, logic fl);
        exp_pix.push_back(pix);
        exp_fill.push_back(fl);
    endfunction

    function void check_result(logic signed [15:0] pix, logic fl);
        logic signed [15:0] ep;
        logic               ef;
        if (exp_pix.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected item pixel_out=%0d filled=%0b", $time, pix, fl);
            return;
        end
        ep = exp_pix.pop_front();
        ef = exp_fill.pop_front();
        if (pix !== ep)
        begin
            errors++;
            $display("%0t: pixel_out expected %0d actual %0d", $time, ep, pix);
        end
        if (fl !== ef)
        begin
            errors++;
            $display("%0t: filled expected %0b actual %0b", $time, ef, fl);
        end
    endfunction

    function int pending();
        return exp_pix.size();
    endfunction
endclass

module tb;

    localparam int CTRL_IDX = brz_pkg::REG_CONTROL, SH_IDX = brz_pkg::REG_SRC_H;
    localparam int SW_IDX = brz_pkg::REG_SRC_W, TH_IDX = brz_pkg::REG_TGT_H;
    localparam int TW_IDX = brz_pkg::REG_TGT_W, VS_IDX = brz_pkg::REG_VSCALE;
    localparam int HS_IDX = brz_pkg::REG_HSCALE, FILL_IDX = brz_pkg::REG_FILL;
    localparam int CM_ASYM = brz_pkg::MODE_ASYM, CM_PYT = brz_pkg::MODE_PYT;
    localparam int CM_TFNN = brz_pkg::MODE_TFNN, CM_ALIGN = brz_pkg::MODE_ALIGN;
    localparam int CM_CROP = brz_pkg::MODE_CROP;
    localparam logic MODE_LOAD = 1'b0, MODE_REQ = 1'b1;
    localparam longint ONE = 64'd1 << brz_pkg::FRACTION_BITS;
    localparam longint HALF = 64'd1 << (brz_pkg::FRACTION_BITS - 1);

    logic clk, rst_n;
    logic in_valid, in_stall, mode;
    logic [11:0] row, column;
    logic signed [15:0] pixel_in;
    logic out_valid, out_stall;
    logic signed [15:0] pixel_out;
    logic filled;
    logic cfg_valid, cfg_ready;
    logic [2:0] cfg_index;
    logic [23:0] cfg_data;

    logic [23:0] regs[8];
    logic signed [15:0] plane[256][256];
    resize_scoreboard sb;

    bilinear_image_resize u_dut (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #400000000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic longint eff_len(longint v, longint mx);
        if (v == 0) return 1;
        if (v > mx) return mx;
        return v;
    endfunction

    // maps one output coordinate; returns lo, hi, weights and outside flag
    task automatic map_coord(input longint q, input longint sc, input longint tl,
                             input longint sl, output longint lo, output longint hi,
                             output longint wlo, output longint whi, output bit outside);
        longint s, top, c, i, f;
        int cm;
        cm = regs[CTRL_IDX][2:0];
        s = (sc == 0) ? 1 : sc;
        top = (sl - 1) * ONE;
        if (sc == 65536) c = q * ONE;
        else if (cm == CM_ASYM) c = ((q * ONE) * 65536) / s;
        else if (cm == CM_TFNN) c = ((q * ONE + HALF) * 65536) / s;
        else if (cm == CM_ALIGN || cm == CM_CROP)
        begin
            if (tl <= 1) c = (cm == CM_ALIGN) ? 0 : (sl - 1) * HALF;
            else c = (q * (sl - 1) * ONE) / (tl - 1);
        end
        else if (cm == CM_PYT && tl <= 1) c = 0;
        else c = ((q * ONE + HALF) * 65536) / s - HALF;
        outside = (c < 0) || (c > top);
        if (c < 0) c = 0;
        if (c > top) c = top;
        i = c / ONE;
        lo = i;
        hi = (i + 1 < sl) ? i + 1 : sl - 1;
        if (lo == hi)
        begin
            wlo = HALF;
            whi = HALF;
        end
        else
        begin
            f = c - i * ONE;
            wlo = ONE - f;
            whi = f;
        end
    endtask

    task automatic predict_request(input logic [11:0] r, input logic [11:0] c);
        longint sh, sw, th, tw, ylo, yhi, wyl, wyh, xlo, xhi, wxl, wxh, sum, res;
        bit oy, ox;
        sh = eff_len(regs[SH_IDX][8:0], 256);
        sw = eff_len(regs[SW_IDX][8:0], 256);
        th = (regs[TH_IDX][11:0] == 0) ? 1 : regs[TH_IDX][11:0];
        tw = (regs[TW_IDX][11:0] == 0) ? 1 : regs[TW_IDX][11:0];
        map_coord(r, regs[VS_IDX], th, sh, ylo, yhi, wyl, wyh, oy);
        map_coord(c, regs[HS_IDX], tw, sw, xlo, xhi, wxl, wxh, ox);
        if (regs[CTRL_IDX][3] && (oy || ox))
        begin
            sb.note_request(regs[FILL_IDX][15:0], 1'b1);
            return;
        end
        sum = ((wxl * wyl) >>> brz_pkg::FRACTION_BITS) * longint'(plane[ylo][xlo])
            + ((wxh * wyl) >>> brz_pkg::FRACTION_BITS) * longint'(plane[ylo][xhi])
            + ((wxl * wyh) >>> brz_pkg::FRACTION_BITS) * longint'(plane[yhi][xlo])
            + ((wxh * wyh) >>> brz_pkg::FRACTION_BITS) * longint'(plane[yhi][xhi]);
        res = (sum + HALF) >>> brz_pkg::FRACTION_BITS;
        if (res > 32767) res = 32767;
        if (res < -32768) res = -32768;
        sb.note_request(16'(res), 1'b0);
    endtask

    task automatic write_reg(input int idx, input logic [23:0] val);
        cfg_valid <= 1;
        cfg_index <= 3'(idx);
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 0;
        @(posedge clk);
        case (idx)
            CTRL_IDX: regs[idx] = val & 24'hF;
            SH_IDX, SW_IDX: regs[idx] = val & 24'h1FF;
            TH_IDX, TW_IDX: regs[idx] = val & 24'hFFF;
            FILL_IDX: regs[idx] = val & 24'hFFFF;
            default: regs[idx] = val;
        endcase
    endtask

    // valid stays high after the item is taken; a gap before the next item or wait_idle drops it
    task automatic send_item(input logic m, input logic [11:0] r, input logic [11:0] c,
                             input logic [15:0] p);
        int gap;
        gap = $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        mode <= m;
        row <= r;
        column <= c;
        pixel_in <= p;
        do @(posedge clk); while (in_stall);
        if (m == MODE_LOAD)
        begin
            if (r < 256 && c < 256)
                plane[r][c] = p;
        end
        else
            predict_request(r, c);
    endtask

    task automatic wait_idle();
        int guard;
        guard = 0;
        in_valid <= 0;
        while (sb.pending() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (150) @(posedge clk);
    endtask

    // loads the whole source plane used by the current size
    task automatic fill_plane(input int sh, input int sw, input int style);
        logic [15:0] v;
        for (int r = 0; r < sh; r++)
            for (int c = 0; c < sw; c++)
            begin
                case (style)
                    0: v = 16'h7FFF;
                    1: v = 16'h8000;
                    default: v = 16'($urandom);
                endcase
                send_item(MODE_LOAD, 12'(r), 12'(c), v);
            end
    endtask

    task automatic set_geom(input int sh, input int sw, input int th, input int tw);
        write_reg(SH_IDX, 24'(sh));
        write_reg(SW_IDX, 24'(sw));
        write_reg(TH_IDX, 24'(th));
        write_reg(TW_IDX, 24'(tw));
    endtask

    function automatic logic [23:0] rand_scale();
        case ($urandom_range(0, 5))
            0: return 24'd65536;
            1: return 24'd1;
            2: return 24'hFFFFFF;
            3: return 24'd0;
            default: return 24'($urandom_range(16384, 400000));
        endcase
    endfunction

    // receiver: stalls randomly before taking each item, checks every accepted item
    initial
    begin
        int wait_n;
        out_stall = 1;
        @(posedge rst_n);
        wait_n = $urandom_range(0, 4);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                sb.check_result(pixel_out, filled);
                wait_n = $urandom_range(0, 4);
            end
            else if (out_valid && wait_n > 0)
                wait_n--;
            out_stall <= (wait_n != 0);
        end
    end

    initial
    begin
        int sh, sw, th, tw, n, total;
        logic [11:0] r, c;
        sb = new();
        rst_n = 0;
        in_valid = 0;
        mode = 0;
        row = 0;
        column = 0;
        pixel_in = 0;
        cfg_valid = 0;
        cfg_index = 0;
        cfg_data = 0;
        regs[CTRL_IDX] = 0;
        regs[SH_IDX] = 1;
        regs[SW_IDX] = 1;
        regs[TH_IDX] = 1;
        regs[TW_IDX] = 1;
        regs[VS_IDX] = 65536;
        regs[HS_IDX] = 65536;
        regs[FILL_IDX] = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: reset geometry, extreme pixels, big request coordinates
        fill_plane(1, 1, 0);
        send_item(MODE_REQ, 12'd0, 12'd0, 16'hFFFF);
        send_item(MODE_REQ, 12'hFFF, 12'hFFF, 16'h0);
        send_item(MODE_LOAD, 12'hFFF, 12'd0, 16'h1234);   // outside store, ignored
        send_item(MODE_LOAD, 12'd0, 12'hFFF, 16'h1234);
        send_item(MODE_REQ, 12'd0, 12'd0, 16'h0);
        wait_idle();
        set_geom(2, 2, 4, 4);
        write_reg(FILL_IDX, 24'h8000);
        fill_plane(2, 2, 1);
        for (int m = 0; m < 8; m++)
        begin
            wait_idle();
            write_reg(CTRL_IDX, 24'(m | ((m & 1) << 3)));
            write_reg(VS_IDX, (m == 0) ? 24'd0 : 24'd131072);
            write_reg(HS_IDX, 24'd131072);
            send_item(MODE_REQ, 12'(m & 3), 12'd3, 16'h0);
            send_item(MODE_REQ, 12'hFFF, 12'd0, 16'h0);
        end
        wait_idle();
        // extreme sizes: sizes above the store saturate, zero acts as one
        set_geom(0, 511, 0, 4095);
        write_reg(CTRL_IDX, 24'd12);
        fill_plane(1, 256, 2);
        send_item(MODE_REQ, 12'd0, 12'd4094, 16'h0);
        send_item(MODE_REQ, 12'd0, 12'd0, 16'h0);
        wait_idle();

        // random phases
        total = 0;
        while (total < 1950)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                sh = $urandom_range(0, 1) ? 256 : $urandom_range(1, 256);
                sw = $urandom_range(1, 4);
            end
            else
            begin
                sh = $urandom_range(1, 5);
                sw = $urandom_range(1, 5);
            end
            // keep the item count near the target
            if (total + sh * sw > 1900)
            begin
                sh = $urandom_range(1, 5);
                sw = $urandom_range(1, 5);
            end
            th = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 12);
            tw = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 4095) : $urandom_range(2, 12);
            wait_idle();
            set_geom(sh, sw, th, tw);
            write_reg(CTRL_IDX, 24'($urandom_range(0, 15)));
            write_reg(VS_IDX, rand_scale());
            write_reg(HS_IDX, rand_scale());
            write_reg(FILL_IDX, 24'($urandom_range(0, 65535)));
            fill_plane(sh, sw, 2);
            total += sh * sw;
            n = $urandom_range(10, 30);
            for (int k = 0; k < n; k++)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    // overwrite an existing pixel or hit an out-of-store address
                    r = $urandom_range(0, 1) ? 12'($urandom_range(0, sh - 1)) : 12'($urandom);
                    c = $urandom_range(0, 1) ? 12'($urandom_range(0, sw - 1)) : 12'($urandom);
                    if (r < 256 && c < 256 && !(r < sh && c < sw)) r = 12'd300;
                    send_item(MODE_LOAD, r, c, 16'($urandom));
                end
                else
                begin
                    r = $urandom_range(0, 5) ? 12'($urandom_range(0, th + 1)) : 12'($urandom);
                    c = $urandom_range(0, 5) ? 12'($urandom_range(0, tw + 1)) : 12'($urandom);
                    send_item(MODE_REQ, r, c, 16'($urandom));
                end
                total++;
            end
        end
        wait_idle();

        if (sb.errors == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

>>> sim.f
hdl/brz_pkg.sv
hdl/brz_ram.sv
hdl/brz_datapath.sv
hdl/brz_ctrl.sv
hdl/bilinear_image_resize.sv
dv/tb.sv
